>>> src/ffra_pkg.sv
// Shared constants and types for the first-fit region allocator.
`default_nettype none

package ffra_pkg;

   // Size of the managed data area in bytes and number of region records
   localparam int DATA_BYTES  = 12288;
   localparam int TABLE_SLOTS = 256;

   // Field widths
   localparam int ADDR_W   = 14;
   localparam int SUM_W    = ADDR_W + 1;
   localparam int SLOT_W   = $clog2(TABLE_SLOTS);
   localparam int CNT_W    = SLOT_W + 1;
   localparam int STATUS_W = 2;

   // Request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 2'd3;

   // One region record as held in the slot table
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
   } slot_rec_type;

   // Probe window [lo, hi) handed to the match unit
   typedef struct packed {
      logic [SUM_W-1:0] lo;
      logic [SUM_W-1:0] hi;
   } probe_type;

endpackage

`default_nettype wire

>>> src/ffra_if.sv
// Valid/ready channel interfaces for allocator requests and responses.
`default_nettype none

interface ffra_req_if import ffra_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [ADDR_W-1:0] request_size;
   logic [ADDR_W-1:0] free_address;

   modport source (output valid, output action, output request_size,
                   output free_address, input ready);
   modport sink   (input valid, input action, input request_size,
                   input free_address, output ready);
endinterface

interface ffra_rsp_if import ffra_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   granted_address;

   modport source (output valid, output status, output granted_address, input ready);
   modport sink   (input valid, input status, input granted_address, output ready);
endinterface

`default_nettype wire

>>> src/ffra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ffra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> src/ffra_match.sv
// Shared overlap unit: tests a probe window against one stored region.
`default_nettype none

module ffra_match import ffra_pkg::*; (
   input  wire  probe_type        probe,
   input  wire  slot_rec_type     region,
   output logic                   hit,
   output logic [SUM_W-1:0]       region_end
);

   // End of region is exclusive; windows overlap when each starts before the other ends
   always_comb begin
      region_end = SUM_W'(region.start) + SUM_W'(region.length);
      hit        = (probe.lo < region_end) && (probe.hi > SUM_W'(region.start));
   end

endmodule

`default_nettype wire

>>> src/first_fit_region_allocator_unit.sv
// Top level of the first-fit region allocator: sequencer, slot table and response register.
`default_nettype none

// First-fit region allocator. Each request beat either allocates a region of
// request_size bytes inside a DATA_BYTES area or frees the region holding
// free_address; exactly one response beat follows each request. Region records
// live in a TABLE_SLOTS-entry RAM read one slot per cycle and fed to a single
// overlap comparator. A free walks the table at most once, stopping at the region
// that holds the address. An allocate walks the table once per candidate
// position: each time the candidate collides with a stored region it jumps to
// that region's end and the walk restarts. A walk ending on a collision stops at
// that slot, and a request whose candidate window runs off the area ends at the
// check that finds it. A stalled response register holds the result in the emit
// state until the register is free. One request is in flight at a time;
// req_bus.ready is high while the sequencer is idle, and a finished response
// waits in an output register without holding up the next request.

module first_fit_region_allocator_unit import ffra_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   ffra_req_if.sink   req_bus,
   ffra_rsp_if.source rsp_bus
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   // Control state
   logic [1:0]             state_ff,    state_in;
   logic [TABLE_SLOTS-1:0] valid_ff,    valid_in;
   logic                   rd_vld_ff,   rd_vld_in;
   logic                   rsp_vld_ff,  rsp_vld_in;

   // Working registers
   logic                   is_free_ff,  is_free_in;
   logic [SUM_W-1:0]       cand_ff,     cand_in;
   logic [SUM_W-1:0]       hi_ff,       hi_in;
   logic [ADDR_W-1:0]      size_ff,     size_in;
   logic [CNT_W-1:0]       iss_ff,      iss_in;
   logic [SLOT_W-1:0]      rd_idx_ff,   rd_idx_in;
   logic                   fs_found_ff, fs_found_in;
   logic [SLOT_W-1:0]      fs_idx_ff,   fs_idx_in;
   logic [STATUS_W-1:0]    st_ff,       st_in;
   logic [ADDR_W-1:0]      grant_ff,    grant_in;
   logic [STATUS_W-1:0]    rsp_st_ff,   rsp_st_in;
   logic [ADDR_W-1:0]      rsp_grant_ff, rsp_grant_in;

   // Table RAM and match unit
   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   slot_rec_type      ram_wdata;
   logic [SLOT_W-1:0] ram_raddr;
   slot_rec_type      ram_rdata;
   probe_type         probe;
   logic              hit;
   logic [SUM_W-1:0]  region_end;
   logic [SUM_W-1:0]  need_end;
   logic              slot_live;
   logic              rsp_free;

   ffra_ram #(
      .WIDTH ($bits(slot_rec_type)),
      .DEPTH (TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign probe.lo = cand_ff;
   assign probe.hi = hi_ff;

   ffra_match u_match (
      .probe      (probe),
      .region     (ram_rdata),
      .hit        (hit),
      .region_end (region_end)
   );

   assign req_bus.ready           = (state_ff == S_IDLE);
   assign rsp_bus.valid           = rsp_vld_ff;
   assign rsp_bus.status          = rsp_st_ff;
   assign rsp_bus.granted_address = rsp_grant_ff;

   assign need_end  = cand_ff + SUM_W'(size_ff);
   assign slot_live = valid_ff[rd_idx_ff];
   assign rsp_free  = !rsp_vld_ff || rsp_bus.ready;
   assign ram_raddr = iss_ff[SLOT_W-1:0];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      rd_vld_in    = 1'b0;
      rsp_vld_in   = rsp_vld_ff && !rsp_bus.ready;
      is_free_in   = is_free_ff;
      cand_in      = cand_ff;
      hi_in        = hi_ff;
      size_in      = size_ff;
      iss_in       = iss_ff;
      rd_idx_in    = rd_idx_ff;
      fs_found_in  = fs_found_ff;
      fs_idx_in    = fs_idx_ff;
      st_in        = st_ff;
      grant_in     = grant_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_grant_in = rsp_grant_ff;
      ram_we       = 1'b0;
      ram_waddr    = fs_idx_ff;
      ram_wdata.start  = cand_ff[ADDR_W-1:0];
      ram_wdata.length = size_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Take a request beat
            if (req_bus.valid) begin
               is_free_in  = (req_bus.action == ACT_FREE);
               size_in     = req_bus.request_size;
               iss_in      = '0;
               fs_found_in = 1'b0;
               grant_in    = '0;
               if (req_bus.action == ACT_FREE) begin
                  cand_in  = SUM_W'(req_bus.free_address);
                  hi_in    = SUM_W'(req_bus.free_address) + SUM_W'(1);
                  state_in = S_SCAN;
               end else begin
                  cand_in  = '0;
                  state_in = S_CHECK;
               end
            end
         end

         S_CHECK: begin
            // Drop out when the size is zero or the candidate window runs off the area
            if (size_ff == '0 || need_end > SUM_W'(DATA_BYTES)) begin
               st_in    = ST_NO_SPACE;
               grant_in = '0;
               state_in = S_EMIT;
            end else begin
               hi_in       = need_end;
               iss_in      = '0;
               fs_found_in = 1'b0;
               state_in    = S_SCAN;
            end
         end

         S_SCAN: begin
            // Issue the next slot read
            if (iss_ff < CNT_W'(TABLE_SLOTS)) begin
               rd_vld_in = 1'b1;
               rd_idx_in = iss_ff[SLOT_W-1:0];
               iss_in    = iss_ff + CNT_W'(1);
            end
            // Evaluate the slot whose record just came back
            if (rd_vld_ff) begin
               if (slot_live && hit) begin
                  rd_vld_in = 1'b0;
                  if (is_free_ff) begin
                     valid_in[rd_idx_ff] = 1'b0;
                     st_in    = ST_OK;
                     grant_in = '0;
                     state_in = S_EMIT;
                  end else begin
                     cand_in  = region_end;
                     state_in = S_CHECK;
                  end
               end else begin
                  if (!slot_live && !fs_found_ff) begin
                     fs_found_in = 1'b1;
                     fs_idx_in   = rd_idx_ff;
                  end
                  if (rd_idx_ff == SLOT_W'(TABLE_SLOTS - 1)) begin
                     rd_vld_in = 1'b0;
                     state_in  = S_EMIT;
                     grant_in  = '0;
                     if (is_free_ff) begin
                        st_in = ST_NOT_ALLOCATED;
                     end else if (fs_found_ff || !slot_live) begin
                        // Record the region in the lowest free slot
                        ram_we    = 1'b1;
                        ram_waddr = fs_found_ff ? fs_idx_ff : rd_idx_ff;
                        valid_in[ram_waddr] = 1'b1;
                        st_in    = ST_OK;
                        grant_in = cand_ff[ADDR_W-1:0];
                     end else begin
                        st_in = ST_TABLE_FULL;
                     end
                  end
               end
            end
         end

         S_EMIT: begin
            // Hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_vld_in   = 1'b1;
               rsp_st_in    = st_ff;
               rsp_grant_in = grant_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      is_free_ff   <= is_free_in;
      cand_ff      <= cand_in;
      hi_ff        <= hi_in;
      size_ff      <= size_in;
      iss_ff       <= iss_in;
      rd_idx_ff    <= rd_idx_in;
      fs_found_ff  <= fs_found_in;
      fs_idx_ff    <= fs_idx_in;
      st_ff        <= st_in;
      grant_ff     <= grant_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_grant_ff <= rsp_grant_in;
   end

endmodule

`default_nettype wire
